// ----- hw/rtl/rfa_pkg.sv -----
// ----------------------------------------------------------------------------
// rfa_pkg
// Types and constants shared by the RTP reorder frame assembler modules.
// ----------------------------------------------------------------------------
package rfa_pkg;

  localparam logic [15:0] RTP_FIXED_BYTES = 16'd12;
  localparam logic [1:0]  RTP_VER_TWO     = 2'd2;
  localparam logic [4:0]  CAPACITY_RST    = 5'd31;
  localparam logic [6:0]  PT_RST          = 7'd96;

  // register select, address bit 2
  localparam logic REG_CAPACITY     = 1'b0;
  localparam logic REG_PAYLOAD_TYPE = 1'b1;

  typedef enum logic [2:0] {
    EV_STORED  = 3'd0,
    EV_BAD_LEN = 3'd1,
    EV_BAD_PT  = 3'd2,
    EV_OLD     = 3'd3,
    EV_DUP     = 3'd4,
    EV_BAD_VER = 3'd5,
    EV_FRAME   = 3'd6,
    EV_EVICT   = 3'd7
  } event_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_POST,
    ST_SHIFT,
    ST_INSERT,
    ST_FSTART,
    ST_FIND,
    ST_CALC,
    ST_EMIT,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [15:0] seq;
    logic        marker;
    logic [6:0]  pt;
    logic [1:0]  ver;
    logic [3:0]  cc;
    logic        xf;
    logic [15:0] xw;
    logic        pf;
    logic [7:0]  pad;
    logic [15:0] len;
    logic        ps;
    logic [15:0] handle;
  } pkt_t;

  typedef struct packed {
    event_t      err;
    logic [15:0] hlen;
    logic [15:0] plen;
  } hdr_t;

  typedef struct packed {
    logic [15:0] seq;
    logic [15:0] handle;
    logic [15:0] hlen;
    logic [15:0] plen;
    logic        marker;
    logic        ps;
  } ent_t;

  typedef struct packed {
    event_t      ev;
    logic [15:0] handle;
    logic [15:0] seq;
    logic [15:0] hlen;
    logic [15:0] plen;
    logic        fend;
  } res_t;

endpackage

// ----- hw/rtl/rfa_mem.sv -----
// ----------------------------------------------------------------------------
// rfa_mem
// Packet slot store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rfa_mem import rfa_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int IW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  ent_t          wdata,
  input  logic [IW-1:0] raddr,
  output ent_t          rdata
);

  ent_t mem [DEPTH];
  ent_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/rfa_hdr.sv -----
// ----------------------------------------------------------------------------
// rfa_hdr
// Header/payload length unit with the length and version checks, registered.
// ----------------------------------------------------------------------------
module rfa_hdr import rfa_pkg::*; (
  input  logic clk,
  input  pkt_t pkt_i,
  output hdr_t hdr_o
);

  hdr_t        hdr_r;
  hdr_t        hdr_nxt;
  logic [5:0]  cc4;
  logic [17:0] xw4;
  logic [18:0] ext;
  logic [7:0]  padv;
  logic [19:0] hsum;
  logic [20:0] pl;

  always_comb begin
    cc4  = {pkt_i.cc, 2'b00};
    xw4  = {pkt_i.xw, 2'b00};
    ext  = pkt_i.xf ? (19'(xw4) + 19'd4) : 19'd0;
    padv = pkt_i.pf ? pkt_i.pad : 8'd0;
    hsum = 20'(RTP_FIXED_BYTES) + 20'(cc4) + 20'(ext);
    // magnitudes stay below 2^20, so bit 20 is the sign
    pl   = 21'(pkt_i.len) - 21'(hsum) - 21'(padv);

    hdr_nxt.hlen = hsum[15:0];
    hdr_nxt.plen = pl[15:0];
    if (pkt_i.len <= RTP_FIXED_BYTES) begin
      hdr_nxt.err = EV_BAD_LEN;
    end else if (pkt_i.ver != RTP_VER_TWO) begin
      hdr_nxt.err = EV_BAD_VER;
    end else if (pkt_i.len < 16'(cc4)) begin
      hdr_nxt.err = EV_BAD_LEN;
    end else if (pkt_i.xf && (18'(pkt_i.len) < xw4)) begin
      hdr_nxt.err = EV_BAD_LEN;
    end else if (pkt_i.pf && (pkt_i.len < 16'(pkt_i.pad))) begin
      hdr_nxt.err = EV_BAD_LEN;
    end else if (pl[20]) begin
      hdr_nxt.err = EV_BAD_LEN;
    end else begin
      hdr_nxt.err = EV_STORED;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
  end

  assign hdr_o = hdr_r;

endmodule

// ----- hw/rtl/rfa_seq.sv -----
// ----------------------------------------------------------------------------
// rfa_seq
// Sequencer: duplicate/position scan, ordered insert, frame search, emit.
// ----------------------------------------------------------------------------
module rfa_seq import rfa_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  pkt_t       pkt_i,
  input  logic [4:0] cap_i,
  input  logic [6:0] pt_i,
  output logic       out_valid,
  input  logic       out_stall,
  output res_t       res_o,
  output logic       last_o
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_t        state_r, state_nxt;
  pkt_t          pkt_r, pkt_nxt;
  logic [CW-1:0] held_r, held_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [15:0]   done_r, done_nxt;
  logic          started_r, started_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] pos_r, pos_nxt;
  logic          dup_r, dup_nxt;
  logic          found_r, found_nxt;
  logic [CW-1:0] flen_r, flen_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [15:0]   prev_r, prev_nxt;
  logic          pend_v_r, pend_v_nxt;
  res_t          pend_r, pend_nxt;
  logic          out_v_r, out_v_nxt;
  res_t          out_r, out_nxt;
  logic          last_r, last_nxt;

  logic          we;
  logic [IW-1:0] waddr;
  ent_t          wdata;
  logic [IW-1:0] raddr;
  ent_t          rdata;
  hdr_t          hdr;

  logic          can_push;
  logic          push;
  res_t          push_res;
  logic          push_last;
  logic [15:0]   diff;
  logic          older_new;
  logic          seq_eq;
  event_t        pre_err;
  event_t        post_err;
  logic [CW+4:0] cap_wide;
  logic [CW-1:0] cap_eff;
  logic          last_idx;
  logic [IW-1:0] idx_inc;
  logic [IW-1:0] idx_dec;
  logic          link_ok;
  logic [CW-1:0] rem;
  logic [CW-1:0] evict_n;
  logic [CW-1:0] ntot;
  logic          emit_end;
  logic [IW:0]   head_sum;
  logic [IW-1:0] head_new;
  logic [15:0]   old_diff;
  ent_t          new_ent;
  res_t          emit_res;
  res_t          err_res;

  rfa_mem #(.DEPTH(DEPTH), .IW(IW)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  rfa_hdr u_hdr (
    .clk   (clk),
    .pkt_i (pkt_r),
    .hdr_o (hdr)
  );

  // logical slot to physical address in the circular store
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] head, input logic [IW-1:0] i);
    logic [IW:0] s;
    s = {1'b0, head} + {1'b0, i};
    if (s >= (IW+1)'(DEPTH)) begin
      s = s - (IW+1)'(DEPTH);
    end
    return s[IW-1:0];
  endfunction

  // shared compare/arithmetic terms
  always_comb begin
    can_push  = !out_v_r || !out_stall;
    diff      = pkt_r.seq - rdata.seq;
    older_new = diff[15];
    seq_eq    = (pkt_r.seq == rdata.seq);
    old_diff  = pkt_r.seq - done_r;

    if (pkt_r.len < RTP_FIXED_BYTES) begin
      pre_err = EV_BAD_LEN;
    end else if (pkt_r.pt != pt_i) begin
      pre_err = EV_BAD_PT;
    end else if (started_r && old_diff[15]) begin
      pre_err = EV_OLD;
    end else begin
      pre_err = EV_STORED;
    end
    post_err = dup_r ? EV_DUP : hdr.err;

    cap_wide = (CW+5)'(cap_i);
    cap_eff  = (cap_wide < (CW+5)'(DEPTH - 1)) ? CW'(cap_wide) : CW'(DEPTH - 1);

    last_idx = (CW'(idx_r) == held_r - CW'(1));
    idx_inc  = idx_r + IW'(1);
    idx_dec  = idx_r - IW'(1);

    // gap check against done_sequence is waived on the oldest packet
    // before the first frame or once the buffer is at capacity
    link_ok = ((prev_r + 16'd1) == rdata.seq) ||
              ((idx_r == '0) && !(started_r && (held_r < cap_eff)));
    if (idx_r == '0) begin
      link_ok = link_ok && rdata.ps;
    end

    rem      = held_r - flen_r;
    evict_n  = (rem > cap_eff) ? (rem - cap_eff) : '0;
    ntot     = flen_r + evict_n;
    emit_end = ((CW'(idx_r) + CW'(1)) == n_r);

    head_sum = (IW+1)'(head_r) + (IW+1)'(n_r);
    head_new = (head_sum >= (IW+1)'(DEPTH)) ? IW'(head_sum - (IW+1)'(DEPTH))
                                             : head_sum[IW-1:0];

    new_ent.seq    = pkt_r.seq;
    new_ent.handle = pkt_r.handle;
    new_ent.hlen   = hdr.hlen;
    new_ent.plen   = hdr.plen;
    new_ent.marker = pkt_r.marker;
    new_ent.ps     = pkt_r.ps;

    emit_res.ev     = (CW'(idx_r) < flen_r) ? EV_FRAME : EV_EVICT;
    emit_res.handle = rdata.handle;
    emit_res.seq    = rdata.seq;
    emit_res.hlen   = rdata.hlen;
    emit_res.plen   = rdata.plen;
    emit_res.fend   = ((CW'(idx_r) + CW'(1)) == flen_r);

    err_res.ev     = EV_STORED;
    err_res.handle = pkt_r.handle;
    err_res.seq    = pkt_r.seq;
    err_res.hlen   = '0;
    err_res.plen   = '0;
    err_res.fend   = 1'b0;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (pre_err != EV_STORED) begin
          if (can_push) state_nxt = ST_IDLE;
        end else if (held_r == '0) begin
          state_nxt = ST_POST;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_idx) state_nxt = ST_POST;
      end
      ST_POST: begin
        if (post_err != EV_STORED) begin
          if (can_push) state_nxt = ST_IDLE;
        end else if (CW'(pos_r) < held_r) begin
          state_nxt = ST_SHIFT;
        end else begin
          state_nxt = ST_INSERT;
        end
      end
      ST_SHIFT: begin
        if (idx_r == pos_r) state_nxt = ST_INSERT;
      end
      ST_INSERT: state_nxt = ST_FSTART;
      ST_FSTART: state_nxt = ST_FIND;
      ST_FIND: begin
        if (!link_ok || rdata.marker || last_idx) state_nxt = ST_CALC;
      end
      ST_CALC: begin
        state_nxt = (ntot == '0) ? ST_FLUSH : ST_EMIT;
      end
      ST_EMIT: begin
        if (can_push && emit_end) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (can_push) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pkt_nxt     = pkt_r;
    held_nxt    = held_r;
    head_nxt    = head_r;
    done_nxt    = done_r;
    started_nxt = started_r;
    idx_nxt     = idx_r;
    pos_nxt     = pos_r;
    dup_nxt     = dup_r;
    found_nxt   = found_r;
    flen_nxt    = flen_r;
    n_nxt       = n_r;
    prev_nxt    = prev_r;
    pend_v_nxt  = pend_v_r;
    pend_nxt    = pend_r;
    we          = 1'b0;
    waddr       = phys(head_r, idx_inc);
    wdata       = rdata;
    raddr       = phys(head_r, idx_r);
    push        = 1'b0;
    push_res    = pend_r;
    push_last   = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) pkt_nxt = pkt_i;
      end
      ST_CHECK: begin
        if (pre_err != EV_STORED) begin
          push        = can_push;
          push_res    = err_res;
          push_res.ev = pre_err;
          push_last   = 1'b1;
        end else begin
          dup_nxt   = 1'b0;
          found_nxt = 1'b0;
          pos_nxt   = IW'(held_r);
          idx_nxt   = '0;
          raddr     = phys(head_r, '0);
        end
      end
      ST_SCAN: begin
        if (seq_eq) dup_nxt = 1'b1;
        if (!found_r && older_new) begin
          pos_nxt   = idx_r;
          found_nxt = 1'b1;
        end
        if (!last_idx) begin
          idx_nxt = idx_inc;
          raddr   = phys(head_r, idx_inc);
        end
      end
      ST_POST: begin
        if (post_err != EV_STORED) begin
          push        = can_push;
          push_res    = err_res;
          push_res.ev = post_err;
          push_last   = 1'b1;
        end else if (CW'(pos_r) < held_r) begin
          idx_nxt = IW'(held_r - CW'(1));
          raddr   = phys(head_r, IW'(held_r - CW'(1)));
        end
      end
      ST_SHIFT: begin
        // move slot idx up by one, read the next lower one
        we = 1'b1;
        if (idx_r != pos_r) begin
          idx_nxt = idx_dec;
          raddr   = phys(head_r, idx_dec);
        end
      end
      ST_INSERT: begin
        we              = 1'b1;
        waddr           = phys(head_r, pos_r);
        wdata           = new_ent;
        held_nxt        = held_r + CW'(1);
        pend_v_nxt      = 1'b1;
        pend_nxt        = err_res;
        pend_nxt.ev     = EV_STORED;
        pend_nxt.hlen   = hdr.hlen;
        pend_nxt.plen   = hdr.plen;
      end
      ST_FSTART: begin
        idx_nxt  = '0;
        raddr    = phys(head_r, '0);
        prev_nxt = done_r;
        flen_nxt = '0;
      end
      ST_FIND: begin
        if (link_ok) begin
          prev_nxt = rdata.seq;
          if (rdata.marker) begin
            flen_nxt = CW'(idx_r) + CW'(1);
          end else if (!last_idx) begin
            idx_nxt = idx_inc;
            raddr   = phys(head_r, idx_inc);
          end
        end
      end
      ST_CALC: begin
        n_nxt   = ntot;
        idx_nxt = '0;
        raddr   = phys(head_r, '0);
      end
      ST_EMIT: begin
        if (can_push) begin
          push     = 1'b1;
          pend_nxt = emit_res;
          done_nxt = rdata.seq;
          if (CW'(idx_r) < flen_r) started_nxt = 1'b1;
          if (emit_end) begin
            head_nxt = head_new;
            held_nxt = held_r - n_r;
          end else begin
            idx_nxt = idx_inc;
            raddr   = phys(head_r, idx_inc);
          end
        end
      end
      ST_FLUSH: begin
        if (can_push) begin
          push       = 1'b1;
          push_last  = 1'b1;
          pend_v_nxt = 1'b0;
        end
      end
      default: ;
    endcase

    if (push) begin
      out_v_nxt = 1'b1;
      out_nxt   = push_res;
      last_nxt  = push_last;
    end else begin
      out_v_nxt = out_v_r && out_stall;
      out_nxt   = out_r;
      last_nxt  = last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      held_r    <= '0;
      head_r    <= '0;
      done_r    <= '0;
      started_r <= 1'b0;
      pend_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      held_r    <= held_nxt;
      head_r    <= head_nxt;
      done_r    <= done_nxt;
      started_r <= started_nxt;
      pend_v_r  <= pend_v_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pkt_r   <= pkt_nxt;
    idx_r   <= idx_nxt;
    pos_r   <= pos_nxt;
    dup_r   <= dup_nxt;
    found_r <= found_nxt;
    flen_r  <= flen_nxt;
    n_r     <= n_nxt;
    prev_r  <= prev_nxt;
    pend_r  <= pend_nxt;
    out_r   <= out_nxt;
    last_r  <= last_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_v_r;
  assign res_o     = out_r;
  assign last_o    = last_r;

`ifndef NO_ASSERTIONS
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> held_r < CW'(DEPTH))
    else $error("held count reached buffer depth while idle");

  a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !pend_v_r)
    else $error("pending result left behind at end of request");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> held_r != '0)
    else $error("scan of empty buffer");

  a_emit_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT || state_r == ST_FLUSH) |-> pend_v_r)
    else $error("emit without a pending result");
`endif

endmodule

// ----- hw/rtl/rtp_reorder_frame_assembler_core.sv -----
// ----------------------------------------------------------------------------
// rtp_reorder_frame_assembler_core
// RTP packet checker, sequence-ordered jitter buffer and PS frame assembler.
// ----------------------------------------------------------------------------
// One request is handled at a time; in_stall is high until its last result
// has been handed to the output register. Slot reads go through one read
// port, so a request walks the held packets for the duplicate scan, moves
// one packet at a time for the ordered insert, walks packets in the frame
// search and emits the frame and evicted results one at a time, and any
// output stall holds it up. A request rejected on length, payload type or
// age ends at the first check, one rejected after the duplicate scan ends
// there. No clearing pass is needed after reset.
module rtp_reorder_frame_assembler_core import rfa_pkg::*; #(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_sequence_number,
  input  logic        in_marker,
  input  logic [6:0]  in_payload_type,
  input  logic [1:0]  in_version,
  input  logic [3:0]  in_csrc_count,
  input  logic        in_extension_flag,
  input  logic [15:0] in_extension_words,
  input  logic        in_padding_flag,
  input  logic [7:0]  in_padding_count,
  input  logic [15:0] in_packet_length,
  input  logic        in_ps_start,
  input  logic [15:0] in_packet_handle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_res,
  output logic [15:0] out_handle_out,
  output logic [15:0] out_sequence_out,
  output logic [15:0] out_header_length,
  output logic [15:0] out_payload_length,
  output logic        out_frame_end,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [4:0] cap_r, cap_nxt;
  logic [6:0] pt_r, pt_nxt;
  logic       wr_en;
  pkt_t       pkt;
  res_t       res;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cap_nxt = cap_r;
    pt_nxt  = pt_r;
    if (wr_en) begin
      case (paddr[2])
        REG_CAPACITY:     cap_nxt = pwdata[4:0];
        REG_PAYLOAD_TYPE: pt_nxt  = pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_CAPACITY:     prdata = {27'd0, cap_r};
      REG_PAYLOAD_TYPE: prdata = {25'd0, pt_r};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAPACITY_RST;
      pt_r  <= PT_RST;
    end else begin
      cap_r <= cap_nxt;
      pt_r  <= pt_nxt;
    end
  end

  always_comb begin
    pkt.seq    = in_sequence_number;
    pkt.marker = in_marker;
    pkt.pt     = in_payload_type;
    pkt.ver    = in_version;
    pkt.cc     = in_csrc_count;
    pkt.xf     = in_extension_flag;
    pkt.xw     = in_extension_words;
    pkt.pf     = in_padding_flag;
    pkt.pad    = in_padding_count;
    pkt.len    = in_packet_length;
    pkt.ps     = in_ps_start;
    pkt.handle = in_packet_handle;
  end

  rfa_seq #(.DEPTH(BUFFER_DEPTH)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pkt_i     (pkt),
    .cap_i     (cap_r),
    .pt_i      (pt_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_o     (res),
    .last_o    (out_last)
  );

  assign out_event_res      = res.ev;
  assign out_handle_out     = res.handle;
  assign out_sequence_out   = res.seq;
  assign out_header_length  = res.hlen;
  assign out_payload_length = res.plen;
  assign out_frame_end      = res.fend;

endmodule

// ----- tb/rtp_reorder_frame_assembler_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_reorder_frame_assembler_core_tb
// Drives RTP packet headers into the reorder frame assembler and checks every
// result (stored, rejected, frame packet, evicted) against a predictor of the
// jitter buffer, over several capacity and payload type settings.
// ----------------------------------------------------------------------------
module rtp_reorder_frame_assembler_core_tb import rfa_pkg::*;;

  localparam int DEPTH = 32;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    res_t r;
    logic lst;
  } result_exp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_event_res;
  logic [15:0] out_handle_out, out_sequence_out, out_header_length, out_payload_length;
  logic        out_frame_end, out_last;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pkt_t cur = '0;

  // predictor state
  ent_t        slots[DEPTH];
  int          held;
  logic [15:0] done_seq;
  logic        started;
  logic [4:0]  cap_cfg;
  logic [6:0]  pt_cfg;

  pkt_t        pkt_q[$];
  result_exp_t result_q[$];
  int          fails = 0;
  bit          in_taken = 0;
  bit          calm = 0;
  bit          long_req = 0;
  int          gap_left = 0;
  logic [15:0] seq_base;

  always #6 clk = ~clk;

  rtp_reorder_frame_assembler_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_sequence_number(cur.seq), .in_marker(cur.marker), .in_payload_type(cur.pt),
    .in_version(cur.ver), .in_csrc_count(cur.cc), .in_extension_flag(cur.xf),
    .in_extension_words(cur.xw), .in_padding_flag(cur.pf), .in_padding_count(cur.pad),
    .in_packet_length(cur.len), .in_ps_start(cur.ps), .in_packet_handle(cur.handle),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_event_res(out_event_res), .out_handle_out(out_handle_out),
    .out_sequence_out(out_sequence_out), .out_header_length(out_header_length),
    .out_payload_length(out_payload_length), .out_frame_end(out_frame_end),
    .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  function automatic bit seq_older(logic [15:0] a, logic [15:0] b);
    logic [15:0] d;
    d = a - b;
    return d[15];
  endfunction

  task automatic queue_pkt(pkt_t p);
    pkt_q.insert(pkt_q.size(), p);
  endtask

  task automatic push_result(event_t ev, ent_t e, logic fe);
    result_exp_t t;
    t.r.ev = ev;
    t.r.handle = e.handle;
    t.r.seq = e.seq;
    t.r.hlen = e.hlen;
    t.r.plen = e.plen;
    t.r.fend = fe;
    t.lst = 1'b0;
    result_q.insert(result_q.size(), t);
  endtask

  task automatic drop_head(int n);
    for (int i = 0; i + n < held; i++) slots[i] = slots[i + n];
    held -= n;
  endtask

  task automatic predict_packet(pkt_t p);
    int len, hdr, pl, pos, flen;
    event_t err;
    logic [15:0] prev;
    ent_t e;
    result_exp_t t;
    len = p.len;
    err = EV_STORED;
    if (len < 12) err = EV_BAD_LEN;
    else if (p.pt != pt_cfg) err = EV_BAD_PT;
    else if (started && seq_older(p.seq, done_seq)) err = EV_OLD;
    else for (int i = 0; i < held; i++) if (slots[i].seq == p.seq) err = EV_DUP;
    hdr = 12;
    pl = len - 12;
    if (err == EV_STORED) begin
      if (len <= 12) err = EV_BAD_LEN;
      else if (p.ver != RTP_VER_TWO) err = EV_BAD_VER;
      else if (len < p.cc * 4) err = EV_BAD_LEN;
      else begin
        hdr += p.cc * 4;
        pl -= p.cc * 4;
        if (p.xf) begin
          if (len < p.xw * 4) err = EV_BAD_LEN;
          else begin
            pl -= 4 + p.xw * 4;
            hdr += 4 + p.xw * 4;
          end
        end
        if (err == EV_STORED && p.pf) begin
          if (len < p.pad) err = EV_BAD_LEN;
          else pl -= p.pad;
        end
        if (err == EV_STORED && pl < 0) err = EV_BAD_LEN;
      end
    end
    e.seq = p.seq;
    e.handle = p.handle;
    e.marker = p.marker;
    e.ps = p.ps;
    if (err != EV_STORED) begin
      e.hlen = '0;
      e.plen = '0;
      push_result(err, e, 1'b0);
    end else begin
      e.hlen = hdr[15:0];
      e.plen = pl[15:0];
      pos = held;
      for (int i = 0; i < held; i++)
        if (seq_older(p.seq, slots[i].seq)) begin
          pos = i;
          break;
        end
      for (int i = held; i > pos; i--) slots[i] = slots[i - 1];
      slots[pos] = e;
      held++;
      push_result(EV_STORED, e, 1'b0);
      // frame must start at a pack header and run to a marker without gaps
      prev = done_seq;
      flen = 0;
      for (int i = 0; i < held; i++) begin
        if (i == 0) begin
          if (!slots[0].ps) break;
          if (started && held < cap_cfg && prev + 16'd1 != slots[0].seq) break;
        end else if (prev + 16'd1 != slots[i].seq) break;
        prev = slots[i].seq;
        if (slots[i].marker) begin
          flen = i + 1;
          break;
        end
      end
      if (flen > 0) begin
        for (int i = 0; i < flen; i++) push_result(EV_FRAME, slots[i], i + 1 == flen);
        done_seq = slots[flen - 1].seq;
        started = 1'b1;
        drop_head(flen);
      end
      while (held > cap_cfg) begin
        push_result(EV_EVICT, slots[0], 1'b0);
        done_seq = slots[0].seq;
        drop_head(1);
      end
    end
    t = result_q.pop_back();
    t.lst = 1'b1;
    result_q.insert(result_q.size(), t);
  endtask

  // accept side: predict on each accepted request, check each result
  always @(posedge clk) begin
    result_exp_t t;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_packet(cur);
        in_taken = 1;
      end
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $error("unexpected result: event_res %0d seq %0d", out_event_res, out_sequence_out);
          fails++;
        end else begin
          t = result_q.pop_front();
          if (out_event_res != t.r.ev) begin
            $error("event_res expected %0d actual %0d", t.r.ev, out_event_res); fails++;
          end
          if (out_handle_out != t.r.handle) begin
            $error("handle_out expected %0d actual %0d", t.r.handle, out_handle_out); fails++;
          end
          if (out_sequence_out != t.r.seq) begin
            $error("sequence_out expected %0d actual %0d", t.r.seq, out_sequence_out); fails++;
          end
          if (out_header_length != t.r.hlen) begin
            $error("header_length expected %0d actual %0d", t.r.hlen, out_header_length);
            fails++;
          end
          if (out_payload_length != t.r.plen) begin
            $error("payload_length expected %0d actual %0d", t.r.plen, out_payload_length);
            fails++;
          end
          if (out_frame_end != t.r.fend) begin
            $error("frame_end expected %0d actual %0d", t.r.fend, out_frame_end); fails++;
          end
          if (out_last != t.lst) begin
            $error("last expected %0d actual %0d", t.lst, out_last); fails++;
          end
        end
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 3);
        in_valid <= 1'b0;
      end else if (pkt_q.size() > 0) begin
        cur = pkt_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver stall
  always @(negedge clk) begin
    int stall_left;
    int hold_left;
    bit long_done;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (long_req && !long_done) begin
      long_done = 1;
      hold_left = 400;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic cfg_write(logic sel, logic [31:0] val);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {sel, 2'b00}; pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (sel == REG_CAPACITY) cap_cfg = val[4:0];
    else pt_cfg = val[6:0];
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pkt_q.size() != 0 || in_valid || result_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic pkt_t good_pkt(logic [15:0] seq, logic m, logic ps);
    pkt_t p;
    p.seq = seq;
    p.marker = m;
    p.ps = ps;
    p.pt = pt_cfg;
    p.ver = RTP_VER_TWO;
    p.cc = ($urandom_range(0, 9) == 0) ? 4'd15 : 4'($urandom_range(0, 3));
    p.xf = 1'($urandom_range(0, 1));
    p.xw = 16'($urandom_range(0, 4));
    p.pf = 1'($urandom_range(0, 1));
    p.pad = 8'($urandom_range(0, 255));
    p.len = 16'(12 + p.cc * 4 + (p.xf ? 4 + p.xw * 4 : 0) + (p.pf ? p.pad : 0)
                + $urandom_range(1, 1400));
    p.handle = 16'($urandom);
    return p;
  endfunction

  // mostly whole frames, shuffled a little, with drops, repeats and noise
  task automatic add_frames(int n);
    pkt_t fr[8];
    pkt_t tmp;
    logic [95:0] rnd;
    int k, cnt;
    cnt = 0;
    while (cnt < n) begin
      k = $urandom_range(1, 6);
      for (int i = 0; i < k; i++)
        fr[i] = good_pkt(seq_base + 16'(i), (i == k - 1) ? ($urandom_range(0, 9) != 0) : 1'b0,
                         (i == 0) ? ($urandom_range(0, 9) != 0) : 1'b0);
      seq_base += 16'(k);
      if ($urandom_range(0, 7) == 0) seq_base += 16'($urandom_range(1, 3));
      for (int i = 0; i + 1 < k; i++)
        if ($urandom_range(0, 3) == 0) begin
          tmp = fr[i]; fr[i] = fr[i + 1]; fr[i + 1] = tmp;
        end
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(0, 12) == 0) continue;
        queue_pkt(fr[i]);
        cnt++;
        if ($urandom_range(0, 19) == 0) begin
          queue_pkt(fr[i]);
          cnt++;
        end
        if ($urandom_range(0, 11) == 0) begin
          rnd = {$urandom, $urandom, $urandom};
          tmp = rnd[$bits(pkt_t)-1:0];
          if ($urandom_range(0, 1)) begin
            tmp.pt = pt_cfg;
            tmp.ver = RTP_VER_TWO;
          end
          queue_pkt(tmp);
          cnt++;
        end
      end
    end
  endtask

  initial begin
    pkt_t p;
    held = 0;
    done_seq = '0;
    started = 1'b0;
    cap_cfg = CAPACITY_RST;
    pt_cfg = PT_RST;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    cfg_write(REG_CAPACITY, 32'd31);
    cfg_write(REG_PAYLOAD_TYPE, 32'd96);

    // rejects: one per length and payload type check, three version values
    p = good_pkt(16'd10, 1'b0, 1'b0); p.len = 16'd5;  queue_pkt(p);
    p = good_pkt(16'd10, 1'b0, 1'b0); p.pt = 7'd0;    queue_pkt(p);
    p = good_pkt(16'd10, 1'b0, 1'b0); p.ver = 2'd3;   queue_pkt(p);
    p = good_pkt(16'd10, 1'b0, 1'b0); p.ver = 2'd0;   queue_pkt(p);
    p = good_pkt(16'd10, 1'b0, 1'b0); p.ver = 2'd1;   queue_pkt(p);
    p = good_pkt(16'd10, 1'b0, 1'b0); p.len = 16'd12; queue_pkt(p);
    p = good_pkt(16'd10, 1'b0, 1'b0); p.cc = 4'd15; p.len = 16'd50; queue_pkt(p);
    p = good_pkt(16'd10, 1'b0, 1'b0); p.xf = 1'b1; p.xw = 16'd100; p.len = 16'd200;
    queue_pkt(p);
    p = good_pkt(16'd10, 1'b0, 1'b0); p.pf = 1'b1; p.pad = 8'd255; p.len = 16'd100;
    queue_pkt(p);
    // payload goes negative after header and extension
    p = good_pkt(16'd10, 1'b0, 1'b0); p.cc = 4'd2; p.xf = 1'b1; p.xw = 16'd10;
    p.pf = 1'b0; p.len = 16'd50; queue_pkt(p);
    // frame across the sequence wrap, arriving out of order
    queue_pkt(good_pkt(16'd65535, 1'b0, 1'b0));
    queue_pkt(good_pkt(16'd65534, 1'b0, 1'b1));
    p = good_pkt(16'd0, 1'b1, 1'b0); p.len = 16'hFFFF; p.handle = 16'hFFFF;
    queue_pkt(p);
    queue_pkt(good_pkt(16'd5, 1'b0, 1'b0));
    queue_pkt(good_pkt(16'd5, 1'b1, 1'b1));   // duplicate
    queue_pkt(good_pkt(16'd65000, 1'b1, 1'b1)); // old
    queue_pkt(good_pkt(16'd65535, 1'b1, 1'b1)); // old
    queue_pkt(good_pkt(16'd1, 1'b1, 1'b1));   // single-packet frame
    queue_pkt(good_pkt(16'd3, 1'b1, 1'b1));   // gap, held back
    wait_drained();

    seq_base = 16'd100;
    cfg_write(REG_CAPACITY, 32'd4);
    cfg_write(REG_PAYLOAD_TYPE, 32'd127);
    long_req = 1;
    add_frames(60);
    wait_drained();

    cfg_write(REG_CAPACITY, 32'd0);
    cfg_write(REG_PAYLOAD_TYPE, 32'd0);
    add_frames(30);
    wait_drained();

    cfg_write(REG_CAPACITY, 32'd31);
    cfg_write(REG_PAYLOAD_TYPE, 32'd96);
    add_frames(50);
    wait_drained();
    add_frames(40);
    wait_drained();

    cfg_write(REG_CAPACITY, 32'd1);
    cfg_write(REG_PAYLOAD_TYPE, 32'd55);
    add_frames(40);
    wait_drained();

    cfg_write(REG_CAPACITY, 32'd12);
    calm = 1;
    add_frames(40);
    wait_drained();

    if (fails == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
